// File: rtl/assert_macros.svh
// Assertion helpers, sampled on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/tlv_ef_pkg.sv
`default_nettype none

package tlv_ef_pkg;

  typedef enum logic [2:0] {
    PH_TYPE_HI = 3'd0,
    PH_TYPE_LO = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// File: rtl/tlv_extension_finder_core.sv
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_stall_o   | data_byte_i, last_byte_i
// result   | out       | out_valid_o / out_stall_i | match_status_o, payload_offset_o,
//          |           |                           | payload_length_o, well_formed_o
// config   | in        | target_type_we_i          | target_type_i
//
// One byte per clock while in_stall_o is low; the record parser state updates in the cycle a byte is taken.
// A result appears in the cycle after the last byte of a buffer is taken.
// The result register is the only output stage: input stalls only while it holds
// a word that the downstream side is stalling.
// Reset clears the parser, the result register and target_type.
`default_nettype none

module tlv_extension_finder_core #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        target_type_we_i,
  input  wire logic [15:0] target_type_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       match_status_o,
  output logic [15:0]      payload_offset_o,
  output logic [15:0]      payload_length_o,
  output logic             well_formed_o
);

  localparam int unsigned PW = $clog2(BUFFER_BYTES + 2);
  localparam logic [31:0] BufBytes = 32'(BUFFER_BYTES);

  logic [15:0] target_q;

  tlv_ef_pkg::phase_e phase_q, phase_d, t_phase;
  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   held_type_q, held_type_d, t_held_type;
  logic [15:0]   left_q, left_d, t_left;
  logic          seen_q, seen_d, t_seen;
  logic [15:0]   moff_q, moff_d, t_moff;
  logic [15:0]   mlen_q, mlen_d, t_mlen;
  logic          mdone_q, mdone_d, t_mdone;

  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [15:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic        wf_q, wf_d;

  logic        accept;
  logic        in_range;
  logic        over;
  logic        boundary;
  logic [15:0] len_word;
  logic [15:0] left_dec;
  logic [31:0] off_full;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_range   = 32'(pos_q) < BufBytes;
  assign over       = ~in_range;
  assign len_word   = {left_q[7:0], data_byte_i};
  assign left_dec   = left_q - 16'd1;
  assign off_full   = 32'(pos_q) + 32'd1;

  // Parser step for one byte.
  always_comb begin
    t_phase     = phase_q;
    t_held_type = held_type_q;
    t_left      = left_q;
    t_seen      = seen_q;
    t_moff      = moff_q;
    t_mlen      = mlen_q;
    t_mdone     = mdone_q;
    if (in_range) begin
      case (phase_q)
        tlv_ef_pkg::PH_TYPE_LO: begin
          t_held_type = {held_type_q[7:0], data_byte_i};
          t_phase     = tlv_ef_pkg::PH_LEN_HI;
        end
        tlv_ef_pkg::PH_LEN_HI: begin
          t_left  = {8'd0, data_byte_i};
          t_phase = tlv_ef_pkg::PH_LEN_LO;
        end
        tlv_ef_pkg::PH_LEN_LO: begin
          if (!seen_q && held_type_q == target_q) begin
            t_seen  = 1'b1;
            t_moff  = (off_full > 32'(tlv_ef_pkg::OFFSET_MAX)) ?
                      tlv_ef_pkg::OFFSET_MAX : off_full[15:0];
            t_mlen  = len_word;
            t_mdone = (len_word == 16'd0);
          end
          t_left  = len_word;
          t_phase = (len_word == 16'd0) ? tlv_ef_pkg::PH_TYPE_HI : tlv_ef_pkg::PH_PAYLOAD;
        end
        tlv_ef_pkg::PH_PAYLOAD: begin
          t_left = left_dec;
          if (left_dec == 16'd0) begin
            if (seen_q) t_mdone = 1'b1;
            t_phase = tlv_ef_pkg::PH_TYPE_HI;
          end
        end
        default: begin
          t_held_type = {8'd0, data_byte_i};
          t_phase     = tlv_ef_pkg::PH_TYPE_LO;
        end
      endcase
    end
  end

  // Result for the last byte, taken from the post-step state.
  always_comb begin
    boundary = (t_phase == tlv_ef_pkg::PH_TYPE_HI) && !over;
    if (!over && t_seen && t_mdone) begin
      status_d = tlv_ef_pkg::STATUS_FOUND;
      off_d    = t_moff;
      len_d    = t_mlen;
    end else begin
      status_d = boundary ? tlv_ef_pkg::STATUS_NOT_FOUND : tlv_ef_pkg::STATUS_MALFORMED;
      off_d    = 16'd0;
      len_d    = 16'd0;
    end
    wf_d = boundary;
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    held_type_d = held_type_q;
    left_d      = left_q;
    seen_d      = seen_q;
    moff_d      = moff_q;
    mlen_d      = mlen_q;
    mdone_d     = mdone_q;
    if (accept) begin
      if (last_byte_i) begin
        // drop the parse and start the next buffer from scratch
        phase_d     = tlv_ef_pkg::PH_TYPE_HI;
        pos_d       = '0;
        held_type_d = '0;
        left_d      = '0;
        seen_d      = 1'b0;
        moff_d      = '0;
        mlen_d      = '0;
        mdone_d     = 1'b0;
      end else begin
        phase_d     = t_phase;
        pos_d       = in_range ? PW'(off_full) : PW'(BufBytes + 32'd1);
        held_type_d = t_held_type;
        left_d      = t_left;
        seen_d      = t_seen;
        moff_d      = t_moff;
        mlen_d      = t_mlen;
        mdone_d     = t_mdone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      phase_q     <= tlv_ef_pkg::PH_TYPE_HI;
      pos_q       <= '0;
      held_type_q <= '0;
      left_q      <= '0;
      seen_q      <= 1'b0;
      moff_q      <= '0;
      mlen_q      <= '0;
      mdone_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (target_type_we_i) target_q <= target_type_i;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      held_type_q <= held_type_d;
      left_q      <= left_d;
      seen_q      <= seen_d;
      moff_q      <= moff_d;
      mlen_q      <= mlen_d;
      mdone_q     <= mdone_d;
      if (accept && last_byte_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      off_q    <= '0;
      len_q    <= '0;
      wf_q     <= 1'b0;
    end else if (accept && last_byte_i) begin
      status_q <= status_d;
      off_q    <= off_d;
      len_q    <= len_d;
      wf_q     <= wf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_status_o   = status_q;
  assign payload_offset_o = off_q;
  assign payload_length_o = len_q;
  assign well_formed_o    = wf_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_last_gives_word, accept && last_byte_i |=> out_valid_o,
              "last byte without result")
  `ASSERT_CLK(a_last_clears,
              accept && last_byte_i |=> phase_q == tlv_ef_pkg::PH_TYPE_HI && pos_q == '0,
              "parser not cleared after last byte")
  `ASSERT_CLK(a_zero_unless_found,
              out_valid_o && match_status_o != tlv_ef_pkg::STATUS_FOUND |->
              payload_offset_o == 16'd0 && payload_length_o == 16'd0,
              "offset or length set without match")
  `ASSERT_NEVER(a_wf_not_malformed,
                out_valid_o && well_formed_o && match_status_o == tlv_ef_pkg::STATUS_MALFORMED,
                "well formed buffer marked malformed")
  `ASSERT_NEVER(a_stall_only_full, in_stall_o && !out_valid_o,
                "input stalled with empty result register")

endmodule

`default_nettype wire
